// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands used by the RTL file that checks itself.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clock, muted during reset.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, muted during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/alucc_pkg.sv =====
// ----------------------------------------------------------------------------
// alucc_pkg
// Shared widths, operation codes, result word type and small helper functions.
// ----------------------------------------------------------------------------
package alucc_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int HALF_WIDTH = DATA_WIDTH / 2;
   localparam int SHIFT_BITS = $clog2(DATA_WIDTH);
   localparam int COUNT_BITS = $clog2(DATA_WIDTH);
   localparam int OP_BITS    = 5;

   typedef enum logic [OP_BITS-1:0] {
      OP_MOV  = 5'd0,
      OP_ADD  = 5'd1,
      OP_SUB  = 5'd2,
      OP_SWAP = 5'd3,
      OP_MUL  = 5'd4,
      OP_DIV  = 5'd5,
      OP_CMP  = 5'd6,
      OP_SHL  = 5'd7,
      OP_SHR  = 5'd8,
      OP_AND  = 5'd9,
      OP_OR   = 5'd10,
      OP_XOR  = 5'd11,
      OP_LDL  = 5'd12,
      OP_LDH  = 5'd13,
      OP_NOT  = 5'd14,
      OP_JMP  = 5'd15,
      OP_JZ   = 5'd16,
      OP_JP   = 5'd17,
      OP_JN   = 5'd18,
      OP_JNZ  = 5'd19,
      OP_JNP  = 5'd20,
      OP_JNN  = 5'd21
   } op_type;

   typedef enum logic [1:0] {
      EXTRA_NONE      = 2'd0,
      EXTRA_REMAINDER = 2'd1,
      EXTRA_SECOND    = 2'd2
   } extra_kind_type;

   // Functions of the shared unit
   typedef enum logic [3:0] {
      FN_ADD,
      FN_SUB,
      FN_AND,
      FN_OR,
      FN_XOR,
      FN_SHL,
      FN_SHR,
      FN_NOT,
      FN_PASS_Y,
      FN_LDL,
      FN_LDH
   } unit_func_type;

   // Flag bit positions
   localparam int FLAG_Z = 0;
   localparam int FLAG_N = 1;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] result_value;
      logic                         write_result;
      logic signed [DATA_WIDTH-1:0] extra_value;
      extra_kind_type               extra_kind;
      logic                         zero_flag;
      logic                         negative_flag;
      logic                         take_jump;
      logic                         divide_by_zero;
   } rsp_word_type;

   function automatic logic [1:0] flags_of(input logic [DATA_WIDTH-1:0] r);
      logic [1:0] f;
      f = '0;
      if (r == '0) begin
         f[FLAG_Z] = 1'b1;
      end else if (r[DATA_WIDTH-1]) begin
         f[FLAG_N] = 1'b1;
      end
      return f;
   endfunction

   function automatic logic jump_taken(input logic [OP_BITS-1:0] op, input logic [1:0] cc);
      logic j;
      j = 1'b0;
      unique case (op)
         OP_JMP:  j = 1'b1;
         OP_JZ:   j = cc[FLAG_Z];
         OP_JP:   j = (cc == 2'b00);
         OP_JN:   j = cc[FLAG_N];
         OP_JNZ:  j = !cc[FLAG_Z];
         OP_JNP:  j = (cc != 2'b00);
         OP_JNN:  j = !cc[FLAG_N];
         default: j = 1'b0;
      endcase
      return j;
   endfunction

   function automatic unit_func_type unit_func_of(input logic [OP_BITS-1:0] op);
      unit_func_type fn;
      fn = FN_PASS_Y;
      unique case (op) inside
         OP_ADD:          fn = FN_ADD;
         OP_SUB, OP_CMP:  fn = FN_SUB;
         OP_SHL:          fn = FN_SHL;
         OP_SHR:          fn = FN_SHR;
         OP_AND:          fn = FN_AND;
         OP_OR:           fn = FN_OR;
         OP_XOR:          fn = FN_XOR;
         OP_LDL:          fn = FN_LDL;
         OP_LDH:          fn = FN_LDH;
         OP_NOT:          fn = FN_NOT;
         default:         fn = FN_PASS_Y;
      endcase
      return fn;
   endfunction

   // Operations that update the flags in a single pass
   function automatic logic sets_flags(input logic [OP_BITS-1:0] op);
      logic s;
      unique case (op) inside
         OP_ADD, OP_SUB, OP_CMP, OP_SHL, OP_SHR,
         OP_AND, OP_OR, OP_XOR, OP_NOT:  s = 1'b1;
         default:                        s = 1'b0;
      endcase
      return s;
   endfunction

endpackage

// ===== hdl/alucc_req_if.sv =====
// ----------------------------------------------------------------------------
// alucc_req_if
// Request channel: operation and two operand values, valid/ready handshake.
// ----------------------------------------------------------------------------
interface alucc_req_if;
   import alucc_pkg::*;

   logic                         valid;
   logic                         ready;
   logic [OP_BITS-1:0]           operation;
   logic signed [DATA_WIDTH-1:0] first_value;
   logic signed [DATA_WIDTH-1:0] second_value_in;

   modport source (
      output valid, operation, first_value, second_value_in,
      input  ready
   );

   modport sink (
      input  valid, operation, first_value, second_value_in,
      output ready
   );
endinterface

// ===== hdl/alucc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// alucc_rsp_if
// Response channel: result word with flags and status, valid/ready handshake.
// ----------------------------------------------------------------------------
interface alucc_rsp_if;
   import alucc_pkg::*;

   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] result_value;
   logic                         write_result;
   logic signed [DATA_WIDTH-1:0] extra_value;
   logic [1:0]                   extra_kind;
   logic                         zero_flag;
   logic                         negative_flag;
   logic                         take_jump;
   logic                         divide_by_zero;

   modport source (
      output valid, result_value, write_result, extra_value, extra_kind,
             zero_flag, negative_flag, take_jump, divide_by_zero,
      input  ready
   );

   modport sink (
      input  valid, result_value, write_result, extra_value, extra_kind,
             zero_flag, negative_flag, take_jump, divide_by_zero,
      output ready
   );
endinterface

// ===== hdl/alucc_shared_unit.sv =====
// ----------------------------------------------------------------------------
// alucc_shared_unit
// The one arithmetic/logic/shift unit, reused on every pass by the sequencer.
// ----------------------------------------------------------------------------
module alucc_shared_unit (
   input  alucc_pkg::unit_func_type        func,
   input  logic [alucc_pkg::DATA_WIDTH-1:0] x,
   input  logic [alucc_pkg::DATA_WIDTH-1:0] y,
   output logic [alucc_pkg::DATA_WIDTH-1:0] result,
   output logic                            carry
);
   import alucc_pkg::*;

   logic                  subtract;
   logic [DATA_WIDTH:0]   sum;
   logic [SHIFT_BITS-1:0] amount;

   // Carry out of a subtract means x >= y, unsigned
   assign subtract = (func == FN_SUB);
   assign sum      = {1'b0, x} + {1'b0, (subtract ? ~y : y)} + {{DATA_WIDTH{1'b0}}, subtract};
   assign carry    = sum[DATA_WIDTH];
   assign amount   = y[SHIFT_BITS-1:0];

   always_comb begin
      unique case (func)
         FN_ADD, FN_SUB: result = sum[DATA_WIDTH-1:0];
         FN_AND:         result = x & y;
         FN_OR:          result = x | y;
         FN_XOR:         result = x ^ y;
         FN_SHL:         result = x << amount;
         FN_SHR:         result = DATA_WIDTH'($signed(x) >>> amount);
         FN_NOT:         result = ~x;
         FN_PASS_Y:      result = y;
         FN_LDL:         result = {x[DATA_WIDTH-1:HALF_WIDTH], y[HALF_WIDTH-1:0]};
         FN_LDH:         result = {y[DATA_WIDTH-HALF_WIDTH-1:0], x[HALF_WIDTH-1:0]};
         default:        result = y;
      endcase
   end
endmodule

// ===== hdl/alucc_engine.sv =====
// ----------------------------------------------------------------------------
// alucc_engine
// Sequencer: each operation makes zero, one or many shared-unit passes.
// ----------------------------------------------------------------------------
module alucc_engine (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start_valid,
   output logic                                   start_ready,
   input  logic [alucc_pkg::OP_BITS-1:0]          operation,
   input  logic signed [alucc_pkg::DATA_WIDTH-1:0] first_value,
   input  logic signed [alucc_pkg::DATA_WIDTH-1:0] second_value_in,
   output logic                                   done_valid,
   input  logic                                   done_ready,
   output alucc_pkg::rsp_word_type                done_word
);
   import alucc_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_EXEC,
      S_MUL,
      S_NEG_A,
      S_NEG_B,
      S_DIV,
      S_NEG_Q,
      S_NEG_R,
      S_DONE
   } state_type;

   localparam logic [COUNT_BITS-1:0] LAST_STEP = COUNT_BITS'(DATA_WIDTH - 1);

   state_type               state_ff,  state_in;
   logic [OP_BITS-1:0]      op_ff,     op_in;
   logic [DATA_WIDTH-1:0]   x_ff,      x_in;
   logic [DATA_WIDTH-1:0]   y_ff,      y_in;
   logic [DATA_WIDTH-1:0]   acc_ff,    acc_in;
   logic [COUNT_BITS-1:0]   count_ff,  count_in;
   logic                    neg_a_ff,  neg_a_in;
   logic                    neg_b_ff,  neg_b_in;
   logic [1:0]              flags_ff,  flags_in;
   rsp_word_type            word_ff,   word_in;

   unit_func_type           unit_func;
   logic [DATA_WIDTH-1:0]   unit_x;
   logic [DATA_WIDTH-1:0]   unit_y;
   logic [DATA_WIDTH-1:0]   unit_result;
   logic                    unit_carry;
   logic [DATA_WIDTH-1:0]   partial;

   alucc_shared_unit u_unit (
      .func   (unit_func),
      .x      (unit_x),
      .y      (unit_y),
      .result (unit_result),
      .carry  (unit_carry)
   );

   assign start_ready = (state_ff == S_IDLE);
   assign done_valid  = (state_ff == S_DONE);
   assign partial     = {acc_ff[DATA_WIDTH-2:0], x_ff[DATA_WIDTH-1]};

   always_comb begin
      done_word               = word_ff;
      done_word.zero_flag     = flags_ff[FLAG_Z];
      done_word.negative_flag = flags_ff[FLAG_N];
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      acc_in    = acc_ff;
      count_in  = count_ff;
      neg_a_in  = neg_a_ff;
      neg_b_in  = neg_b_ff;
      flags_in  = flags_ff;
      word_in   = word_ff;
      unit_func = FN_ADD;
      unit_x    = x_ff;
      unit_y    = y_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start_valid) begin
               op_in    = operation;
               x_in     = first_value;
               y_in     = second_value_in;
               acc_in   = '0;
               count_in = '0;
               word_in  = '0;
               unique case (operation) inside
                  OP_MUL: begin
                     state_in = S_MUL;
                  end
                  OP_DIV: begin
                     if (second_value_in == '0) begin
                        word_in.divide_by_zero = 1'b1;
                        state_in               = S_DONE;
                     end else begin
                        state_in = S_NEG_A;
                     end
                  end
                  [OP_JMP:OP_JNN]: begin
                     word_in.take_jump = jump_taken(operation, flags_ff);
                     state_in          = S_DONE;
                  end
                  OP_MOV, OP_ADD, OP_SUB, OP_SWAP, OP_CMP, OP_SHL, OP_SHR,
                  OP_AND, OP_OR, OP_XOR, OP_LDL, OP_LDH, OP_NOT: begin
                     state_in = S_EXEC;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         S_EXEC: begin
            unit_func = unit_func_of(op_ff);
            if (op_ff != OP_CMP) begin
               word_in.write_result = 1'b1;
               word_in.result_value = unit_result;
            end
            if (op_ff == OP_SWAP) begin
               word_in.extra_value = x_ff;
               word_in.extra_kind  = EXTRA_SECOND;
            end
            if (sets_flags(op_ff)) begin
               flags_in = flags_of(unit_result);
            end
            state_in = S_DONE;
         end

         // Shift-add: one partial product per pass
         S_MUL: begin
            unit_x   = acc_ff;
            unit_y   = y_ff[0] ? x_ff : '0;
            acc_in   = unit_result;
            x_in     = x_ff << 1;
            y_in     = y_ff >> 1;
            count_in = count_ff + 1'b1;
            if (count_ff == LAST_STEP) begin
               word_in.result_value = unit_result;
               word_in.write_result = 1'b1;
               flags_in             = flags_of(unit_result);
               state_in             = S_DONE;
            end
         end

         S_NEG_A: begin
            unit_func = FN_SUB;
            unit_x    = '0;
            unit_y    = x_ff;
            neg_a_in  = x_ff[DATA_WIDTH-1];
            if (x_ff[DATA_WIDTH-1]) begin
               x_in = unit_result;
            end
            state_in = S_NEG_B;
         end

         S_NEG_B: begin
            unit_func = FN_SUB;
            unit_x    = '0;
            unit_y    = y_ff;
            neg_b_in  = y_ff[DATA_WIDTH-1];
            if (y_ff[DATA_WIDTH-1]) begin
               y_in = unit_result;
            end
            state_in = S_DIV;
         end

         // Restoring divide: one quotient bit per pass
         S_DIV: begin
            unit_func = FN_SUB;
            unit_x    = partial;
            unit_y    = y_ff;
            if (unit_carry) begin
               acc_in = unit_result;
               x_in   = {x_ff[DATA_WIDTH-2:0], 1'b1};
            end else begin
               acc_in = partial;
               x_in   = {x_ff[DATA_WIDTH-2:0], 1'b0};
            end
            count_in = count_ff + 1'b1;
            if (count_ff == LAST_STEP) begin
               state_in = S_NEG_Q;
            end
         end

         S_NEG_Q: begin
            unit_func = FN_SUB;
            unit_x    = '0;
            unit_y    = x_ff;
            if (neg_a_ff ^ neg_b_ff) begin
               x_in = unit_result;
            end
            state_in = S_NEG_R;
         end

         // Remainder takes the dividend's sign
         S_NEG_R: begin
            unit_func            = FN_SUB;
            unit_x               = '0;
            unit_y               = acc_ff;
            word_in.result_value = x_ff;
            word_in.write_result = 1'b1;
            word_in.extra_value  = neg_a_ff ? unit_result : acc_ff;
            word_in.extra_kind   = EXTRA_REMAINDER;
            flags_in             = flags_of(x_ff);
            state_in             = S_DONE;
         end

         S_DONE: begin
            if (done_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         flags_ff <= '0;
      end else begin
         state_ff <= state_in;
         flags_ff <= flags_in;
      end
      op_ff    <= op_in;
      x_ff     <= x_in;
      y_ff     <= y_in;
      acc_ff   <= acc_in;
      count_ff <= count_in;
      neg_a_ff <= neg_a_in;
      neg_b_ff <= neg_b_in;
      word_ff  <= word_in;
   end
endmodule

// ===== hdl/alucc_output_reg.sv =====
// ----------------------------------------------------------------------------
// alucc_output_reg
// Output word register: frees the sequencer while a result waits downstream.
// ----------------------------------------------------------------------------
module alucc_output_reg (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load_valid,
   output logic                    load_ready,
   input  alucc_pkg::rsp_word_type load_word,
   output logic                    out_valid,
   input  logic                    out_ready,
   output alucc_pkg::rsp_word_type out_word
);
   import alucc_pkg::*;

   logic         valid_ff, valid_in;
   rsp_word_type word_ff,  word_in;

   // Take a new word when empty or when the held one leaves this cycle
   assign load_ready = !valid_ff || out_ready;
   assign out_valid  = valid_ff;
   assign out_word   = word_ff;

   always_comb begin
      valid_in = valid_ff;
      word_in  = word_ff;
      if (load_ready) begin
         valid_in = load_valid;
         if (load_valid) begin
            word_in = load_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      word_ff <= word_in;
   end
endmodule

// ===== hdl/alu_with_condition_codes_core.sv =====
// ----------------------------------------------------------------------------
// alu_with_condition_codes_core
// Execute unit of a small 32-bit machine with zero and negative flags.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one word per instruction: operation, first_value and
//   second_value_in. rsp_ch returns exactly one word per request: the value
//   to write back, the extra value (DIV remainder or SWAP operand), the
//   flags after the operation, the jump decision and divide-by-zero status.
//   Both channels move a word on a clock edge with valid and ready high.
//   A single-pass operation (move, add, logic, shift) runs once through the
//   shared unit; a jump, an unused code or a zero divisor skips the shared
//   unit. The next request is accepted once the sequencer is back in idle,
//   which it reaches as its result moves into the output register. MUL
//   spends 32 passes through the shared adder (one partial product each);
//   DIV spends 32 restoring-subtract passes plus four sign-fix passes on
//   the same adder.
//   Reset (synchronous, active high) clears both flags and empties the
//   output register; no request is in flight afterward.
//   When rsp_ch stalls, the finished word holds in the output register and
//   the sequencer still takes and works on one more request; it then holds
//   its own result until the output register frees up.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module alu_with_condition_codes_core (
   input logic          clock,
   input logic          reset,
   alucc_req_if.sink    req_ch,
   alucc_rsp_if.source  rsp_ch
);
   import alucc_pkg::*;

   logic         done_valid;
   logic         done_ready;
   rsp_word_type done_word;
   logic         out_valid;
   rsp_word_type out_word;

   // Sequencer plus shared unit; holds the condition flags
   alucc_engine u_engine (
      .clock           (clock),
      .reset           (reset),
      .start_valid     (req_ch.valid),
      .start_ready     (req_ch.ready),
      .operation       (req_ch.operation),
      .first_value     (req_ch.first_value),
      .second_value_in (req_ch.second_value_in),
      .done_valid      (done_valid),
      .done_ready      (done_ready),
      .done_word       (done_word)
   );

   // Decouple the sequencer from a stalled receiver
   alucc_output_reg u_output (
      .clock      (clock),
      .reset      (reset),
      .load_valid (done_valid),
      .load_ready (done_ready),
      .load_word  (done_word),
      .out_valid  (out_valid),
      .out_ready  (rsp_ch.ready),
      .out_word   (out_word)
   );

   // Drive the response channel from the output register
   assign rsp_ch.valid          = out_valid;
   assign rsp_ch.result_value   = out_word.result_value;
   assign rsp_ch.write_result   = out_word.write_result;
   assign rsp_ch.extra_value    = out_word.extra_value;
   assign rsp_ch.extra_kind     = out_word.extra_kind;
   assign rsp_ch.zero_flag      = out_word.zero_flag;
   assign rsp_ch.negative_flag  = out_word.negative_flag;
   assign rsp_ch.take_jump      = out_word.take_jump;
   assign rsp_ch.divide_by_zero = out_word.divide_by_zero;

   // Checks on the block's own behavior
   `ASSERT_NEXT(a_busy_after_accept, req_ch.valid && req_ch.ready, !req_ch.ready, "request accepted while sequencer busy")
   `ASSERT_IMPLIES(a_flags_exclusive, rsp_ch.valid, !(rsp_ch.zero_flag && rsp_ch.negative_flag), "zero and negative flags both set")
   `ASSERT_IMPLIES(a_div_zero_no_write, rsp_ch.valid && rsp_ch.divide_by_zero, !rsp_ch.write_result && (rsp_ch.extra_kind == EXTRA_NONE), "divide by zero wrote a result")
   `ASSERT_IMPLIES(a_no_write_zero_value, rsp_ch.valid && !rsp_ch.write_result, rsp_ch.result_value == '0, "unwritten result not zero")
endmodule

// ===== dv/tb_alu_with_condition_codes_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_alu_with_condition_codes_core
// Self-checking bench for the execute unit with zero and negative flags.
// Drives instruction words through the request channel, tracks the flags in
// a local model, and checks every result word against it field by field.
// A directed corner run comes first, then three random runs with the sender
// and the receiver idling at different rates.
// ----------------------------------------------------------------------------
module tb_alu_with_condition_codes_core;
   import alucc_pkg::*;

   localparam int CLOCK_PERIOD = 10;
   localparam int RESET_CYCLES = 8;
   // DIV is the slowest operation; leave some slack after it.
   localparam int SETTLE_CYCLES = 50;
   localparam int REPORT_LIMIT = 10;
   localparam int OP_CODE_MAX = (1 << OP_BITS) - 1;

   localparam logic [DATA_WIDTH-1:0] VALUE_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
   localparam logic [DATA_WIDTH-1:0] VALUE_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

   logic clock = 1'b0;
   logic reset;

   alucc_req_if req_ch ();
   alucc_rsp_if rsp_ch ();

   alu_with_condition_codes_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Local copy of the condition flags, advanced once per accepted word
   logic [1:0] flags_now;
   // Result words still owed by the block, oldest first
   rsp_word_type owed_words[$];
   int error_count;
   // Idle rates in percent for the sender and the receiver
   int req_idle_pct;
   int rsp_stall_pct;

   // -------------------------------------------------------------------------
   // Prediction: work out the result word for one instruction and advance
   // the flags the same way the block must.
   // -------------------------------------------------------------------------
   function automatic rsp_word_type predict_word(input logic [OP_BITS-1:0] op,
                                                 input logic [DATA_WIDTH-1:0] a,
                                                 input logic [DATA_WIDTH-1:0] b);
      rsp_word_type w;
      logic [DATA_WIDTH-1:0] value;
      logic [DATA_WIDTH-1:0] mag_a;
      logic [DATA_WIDTH-1:0] mag_b;
      logic [DATA_WIDTH-1:0] quo;
      logic [DATA_WIDTH-1:0] rem;
      logic [SHIFT_BITS-1:0] count;
      logic written;
      logic updates_flags;
      w = '0;
      value = '0;
      written = 1'b0;
      updates_flags = 1'b0;
      // only the low bits of the source count as shift distance
      count = b[SHIFT_BITS-1:0];
      case (op)
         OP_MOV: begin
            value = b;
            written = 1'b1;
         end
         OP_ADD: begin
            value = a + b;
            written = 1'b1;
            updates_flags = 1'b1;
         end
         OP_SUB: begin
            value = a - b;
            written = 1'b1;
            updates_flags = 1'b1;
         end
         OP_SWAP: begin
            value = b;
            written = 1'b1;
            w.extra_value = a;
            w.extra_kind = EXTRA_SECOND;
         end
         OP_MUL: begin
            value = a * b;
            written = 1'b1;
            updates_flags = 1'b1;
         end
         OP_DIV: begin
            if (b == '0) begin
               // zero divisor: flag it, write nothing, keep the flags
               w.divide_by_zero = 1'b1;
            end else begin
               // divide magnitudes, then fix signs: quotient truncates toward
               // zero, remainder follows the dividend
               mag_a = a[DATA_WIDTH-1] ? -a : a;
               mag_b = b[DATA_WIDTH-1] ? -b : b;
               quo = mag_a / mag_b;
               rem = mag_a % mag_b;
               value = (a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1]) ? -quo : quo;
               w.extra_value = a[DATA_WIDTH-1] ? -rem : rem;
               w.extra_kind = EXTRA_REMAINDER;
               written = 1'b1;
               updates_flags = 1'b1;
            end
         end
         OP_CMP: begin
            value = a - b;
            updates_flags = 1'b1;
         end
         OP_SHL: begin
            value = a << count;
            written = 1'b1;
            updates_flags = 1'b1;
         end
         OP_SHR: begin
            value = $signed(a) >>> count;
            written = 1'b1;
            updates_flags = 1'b1;
         end
         OP_AND: begin
            value = a & b;
            written = 1'b1;
            updates_flags = 1'b1;
         end
         OP_OR: begin
            value = a | b;
            written = 1'b1;
            updates_flags = 1'b1;
         end
         OP_XOR: begin
            value = a ^ b;
            written = 1'b1;
            updates_flags = 1'b1;
         end
         OP_LDL: begin
            value = {a[DATA_WIDTH-1:HALF_WIDTH], b[HALF_WIDTH-1:0]};
            written = 1'b1;
         end
         OP_LDH: begin
            value = {b[DATA_WIDTH-HALF_WIDTH-1:0], a[HALF_WIDTH-1:0]};
            written = 1'b1;
         end
         OP_NOT: begin
            value = ~a;
            written = 1'b1;
            updates_flags = 1'b1;
         end
         OP_JMP: w.take_jump = 1'b1;
         OP_JZ:  w.take_jump = flags_now[FLAG_Z];
         OP_JP:  w.take_jump = (flags_now == '0);
         OP_JN:  w.take_jump = flags_now[FLAG_N];
         OP_JNZ: w.take_jump = !flags_now[FLAG_Z];
         OP_JNP: w.take_jump = (flags_now != '0);
         OP_JNN: w.take_jump = !flags_now[FLAG_N];
         default: ;
      endcase
      if (updates_flags) begin
         flags_now[FLAG_Z] = (value == '0);
         flags_now[FLAG_N] = value[DATA_WIDTH-1];
      end
      w.write_result = written;
      w.result_value = written ? value : '0;
      w.zero_flag = flags_now[FLAG_Z];
      w.negative_flag = flags_now[FLAG_N];
      return w;
   endfunction

   // -------------------------------------------------------------------------
   // Stimulus helpers
   // -------------------------------------------------------------------------

   // Send one instruction word: idle at the configured rate, then hold valid
   // until the block takes the word. Valid stays high on return so that a
   // back-to-back word needs no second assignment in the same step.
   task automatic send_word(input logic [OP_BITS-1:0] op,
                            input logic [DATA_WIDTH-1:0] a,
                            input logic [DATA_WIDTH-1:0] b);
      while ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.operation <= op;
      req_ch.first_value <= a;
      req_ch.second_value_in <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      owed_words.push_back(predict_word(op, a, b));
   endtask

   // Drop valid and hold off until every owed word has come back.
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (owed_words.size() != 0) @(posedge clock);
   endtask

   // Operand values: corners, small values around zero, and full random
   function automatic logic [DATA_WIDTH-1:0] pick_operand();
      int r;
      r = $urandom_range(99);
      if (r < 20) begin
         case ($urandom_range(7))
            0: return '0;
            1: return 1;
            2: return '1;
            3: return VALUE_MIN;
            4: return VALUE_MAX;
            5: return 32'h4000_0000;
            6: return 32'hFFFF_0000;
            default: return 32'h0000_FFFF;
         endcase
      end
      if (r < 35) return $urandom_range(16) - 8;
      return $urandom;
   endfunction

   function automatic logic [OP_BITS-1:0] pick_flag_setter();
      case ($urandom_range(10))
         0: return OP_ADD;
         1: return OP_SUB;
         2: return OP_MUL;
         3: return OP_DIV;
         4: return OP_CMP;
         5: return OP_SHL;
         6: return OP_SHR;
         7: return OP_AND;
         8: return OP_OR;
         9: return OP_XOR;
         default: return OP_NOT;
      endcase
   endfunction

   // Mostly defined operations, MUL and DIV weighted up, a few unused codes
   function automatic logic [OP_BITS-1:0] pick_op();
      int r;
      r = $urandom_range(99);
      if (r < 6) return OP_BITS'($urandom_range(OP_CODE_MAX, OP_JNN + 1));
      if (r < 20) return $urandom_range(1) ? OP_MUL : OP_DIV;
      return OP_BITS'($urandom_range(OP_JNN, OP_MOV));
   endfunction

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // Corners of every operation, with the flags steered so each pair of
   // conditional jumps shows one taken and one not taken.
   task automatic test_directed_corners();
      req_idle_pct = 0;
      rsp_stall_pct = 0;
      send_word(OP_MOV, 32'h1234_5678, VALUE_MAX);
      send_word(OP_ADD, VALUE_MAX, 1);               // wraps to most negative
      send_word(OP_JN, '0, '0);
      send_word(OP_JNN, '0, '0);
      send_word(OP_SUB, VALUE_MIN, 1);               // wraps to most positive
      send_word(OP_JP, '0, '0);
      send_word(OP_JNP, '0, '0);
      send_word(OP_CMP, 32'h4000_0000, 32'h4000_0000);
      send_word(OP_JZ, '0, '0);
      send_word(OP_JNZ, '0, '0);
      send_word(OP_SWAP, VALUE_MIN, '1);
      send_word(OP_MUL, '1, VALUE_MIN);
      send_word(OP_DIV, 5, '0);                      // zero divisor keeps flags
      send_word(OP_DIV, VALUE_MIN, '1);              // overflow wraps
      send_word(OP_DIV, -7, 2);                      // remainder takes dividend sign
      send_word(OP_DIV, 7, -2);
      send_word(OP_SHL, 1, '1);                      // count uses low bits only
      send_word(OP_SHR, VALUE_MIN, 32'hFFFF_FFE4);
      send_word(OP_SHR, VALUE_MAX, 32'h0000_0020);   // count of zero
      send_word(OP_AND, 32'hFFFF_0000, 32'h0000_FFFF);
      send_word(OP_OR, 32'hFFFF_0000, 32'h0000_FFFF);
      send_word(OP_XOR, VALUE_MAX, '1);
      send_word(OP_LDL, 32'hFFFF_0000, 32'h1234_ABCD);
      send_word(OP_LDH, 32'h0000_FFFF, 32'hCAFE_1234);
      send_word(OP_NOT, '0, VALUE_MIN);
      send_word(OP_JMP, VALUE_MIN, VALUE_MAX);
      send_word(OP_BITS'(OP_CODE_MAX), '1, '1);      // unused code does nothing
   endtask

   // Random traffic: flag-setting words followed by a jump that reads the
   // flags, mixed with single random words.
   task automatic test_random_traffic(input int words, input int idle_pct,
                                      input int stall_pct);
      int sent;
      logic [DATA_WIDTH-1:0] a;
      logic [DATA_WIDTH-1:0] b;
      req_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      sent = 0;
      while (sent < words) begin
         if ($urandom_range(99) < 40) begin
            a = pick_operand();
            // equal operands drive SUB, CMP and XOR to zero
            b = ($urandom_range(4) == 0) ? a : pick_operand();
            send_word(pick_flag_setter(), a, b);
            send_word(OP_BITS'($urandom_range(OP_JNN, OP_JMP)), pick_operand(),
                      pick_operand());
            sent += 2;
         end else begin
            send_word(pick_op(), pick_operand(), pick_operand());
            sent++;
         end
      end
   endtask

   // -------------------------------------------------------------------------
   // Result checking
   // -------------------------------------------------------------------------

   function automatic string show_word(input rsp_word_type w);
      return $sformatf("res=%h wr=%b ext=%h kind=%0d z=%b n=%b jump=%b dz=%b",
                       w.result_value, w.write_result, w.extra_value, w.extra_kind,
                       w.zero_flag, w.negative_flag, w.take_jump, w.divide_by_zero);
   endfunction

   // Compare one accepted result word with the oldest owed word.
   task automatic check_word();
      rsp_word_type got;
      rsp_word_type want;
      got.result_value = rsp_ch.result_value;
      got.write_result = rsp_ch.write_result;
      got.extra_value = rsp_ch.extra_value;
      got.extra_kind = extra_kind_type'(rsp_ch.extra_kind);
      got.zero_flag = rsp_ch.zero_flag;
      got.negative_flag = rsp_ch.negative_flag;
      got.take_jump = rsp_ch.take_jump;
      got.divide_by_zero = rsp_ch.divide_by_zero;
      if (owed_words.size() == 0) begin
         error_count++;
         if (error_count <= REPORT_LIMIT) begin
            $display("%0t: result word with none owed: %s", $time, show_word(got));
         end
         return;
      end
      want = owed_words.pop_front();
      if (got.result_value !== want.result_value ||
          got.write_result !== want.write_result ||
          got.extra_value !== want.extra_value ||
          got.extra_kind !== want.extra_kind ||
          got.zero_flag !== want.zero_flag ||
          got.negative_flag !== want.negative_flag ||
          got.take_jump !== want.take_jump ||
          got.divide_by_zero !== want.divide_by_zero) begin
         error_count++;
         if (error_count <= REPORT_LIMIT) begin
            $display("%0t: result mismatch", $time);
            $display("   expected %s", show_word(want));
            $display("   actual   %s", show_word(got));
         end
      end
   endtask

   // Sample the result channel at each edge, then pick the next ready value.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            check_word();
         end
         rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // -------------------------------------------------------------------------
   // Sequence
   // -------------------------------------------------------------------------
   initial begin
      // known values on every input from time zero
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.operation = '0;
      req_ch.first_value = '0;
      req_ch.second_value_in = '0;
      rsp_ch.ready = 1'b0;
      flags_now = '0;
      error_count = 0;
      req_idle_pct = 0;
      rsp_stall_pct = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_corners();
      drain_results();
      // sender mostly busy, receiver stalling hard
      test_random_traffic(275, 25, 86);
      drain_results();
      // sender idling hard, receiver mostly ready
      test_random_traffic(275, 86, 25);
      drain_results();
      // back-to-back traffic, no idling on either side
      test_random_traffic(275, 0, 0);
      drain_results();

      // let any late or stray word show up before the verdict
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && owed_words.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog: a hung handshake ends the run here.
   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
